/* design/hgb_pkg.sv */
// Package for the HDR gamma blend pixel block: beat types, register codes and gamma tables.
package hgb_pkg;

    // Linear light, unsigned Q1.13, one = 8192
    localparam int unsigned LIN_W  = 14;
    localparam int unsigned HDR_W  = 16;
    localparam int unsigned IW_W   = 13;
    localparam int unsigned NUM_CH = 3;
    localparam logic [LIN_W-1:0] Q_ONE = 14'd8192;

    // Divider: quotient width and the stages it is spread over
    localparam int unsigned DIV_Q_W    = 16;
    localparam int unsigned DIV_STAGES = 4;
    // Encoder: binary search over the table, stages it is spread over
    localparam int unsigned ENC_BITS   = 8;
    localparam int unsigned ENC_STAGES = 2;

    // Register reset values
    localparam logic [1:0]      MODE_RESET  = 2'd0;
    localparam logic [HDR_W-1:0] RED_RESET   = 16'd13107;
    localparam logic [HDR_W-1:0] GREEN_RESET = 16'd11469;
    localparam logic [HDR_W-1:0] BLUE_RESET  = 16'd6554;
    localparam logic [IW_W-1:0]  IW_RESET    = 13'd1024;

    typedef enum logic [2:0] {
        CFG_BLEND_MODE  = 3'd0,
        CFG_HDR_RED     = 3'd1,
        CFG_HDR_GREEN   = 3'd2,
        CFG_HDR_BLUE    = 3'd3,
        CFG_IMAGE_WIDTH = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LERP       = 2'd0,
        MODE_LERP_CLAMP = 2'd1,
        MODE_PREMUL     = 2'd2
    } blend_mode_t;

    typedef struct packed {
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
        logic [11:0] column;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [7:0] clip_red;
        logic [7:0] clip_green;
        logic [7:0] clip_blue;
        logic       over_range;
    } pix_out_t;

    typedef logic [LIN_W-1:0] lin_t;
    typedef lin_t lin_tab_t [256];

    // Four truncating Q1.31 multiplies
    function automatic logic [63:0] fifth_pow(logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int i = 0; i < 4; i++)
        begin
            p = (p * y) >> 31;
        end
        return p;
    endfunction

    // (b/255)^2.2 in Q1.31: square times fifth root
    function automatic logic [63:0] gamma_d(int unsigned b);
        logic [63:0] r;
        logic [63:0] sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        r  = (64'(b) << 31) / 64'd255;
        sq = ((64'(b) * 64'(b)) << 31) / 64'd65025;
        lo = 64'd0;
        hi = 64'd1 << 31;
        for (int it = 0; it < 40; it++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                if (fifth_pow(mid) <= r)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
        end
        return (sq * lo) >> 31;
    endfunction

    // Decode: round to Q1.13
    function automatic lin_tab_t build_dec_tab();
        lin_tab_t t;
        for (int b = 0; b < 256; b++)
        begin
            t[b] = LIN_W'((gamma_d(b) + (64'd1 << 17)) >> 18);
        end
        return t;
    endfunction

    // Encode thresholds: smallest Q1.13 value that reaches each code
    function automatic lin_tab_t build_enc_tab();
        lin_tab_t t;
        for (int b = 0; b < 256; b++)
        begin
            t[b] = LIN_W'((gamma_d(b) + (64'd1 << 18) - 64'd1) >> 18);
        end
        return t;
    endfunction

    localparam lin_tab_t DEC_TAB = build_dec_tab();
    localparam lin_tab_t ENC_TAB = build_enc_tab();

endpackage

/* design/hgb_div.sv */
// Pipelined restoring divider: quotient bits split evenly over the divider stages.
module hgb_div #(
    parameter int unsigned DEN_W = 13
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [DEN_W+hgb_pkg::DIV_Q_W-1:0]  num,
    input  logic [DEN_W-1:0]                   den,
    output logic [hgb_pkg::DIV_Q_W-1:0]        quo
);
    import hgb_pkg::*;

    localparam int unsigned STEP = DIV_Q_W / DIV_STAGES;

    logic [DEN_W-1:0]   rem_reg  [DIV_STAGES];
    logic [DIV_Q_W-1:0] lq_reg   [DIV_STAGES];
    logic [DEN_W-1:0]   rem_next [DIV_STAGES];
    logic [DIV_Q_W-1:0] lq_next  [DIV_STAGES];
    logic [DEN_W-1:0]   rem_in   [DIV_STAGES];
    logic [DIV_Q_W-1:0] lq_in    [DIV_STAGES];

    // Feed each stage from the one before, the first from the numerator
    assign rem_in[0] = num[DEN_W+DIV_Q_W-1:DIV_Q_W];
    assign lq_in[0]  = num[DIV_Q_W-1:0];
    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_link
        assign rem_in[s] = rem_reg[s-1];
        assign lq_in[s]  = lq_reg[s-1];
    end

    // Shift, trial subtract, set the quotient bit
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            logic [DEN_W-1:0]   rem;
            logic [DIV_Q_W-1:0] lq;
            logic [DEN_W:0]     trial;
            rem = rem_in[s];
            lq  = lq_in[s];
            for (int k = 0; k < STEP; k++)
            begin
                trial = {rem, lq[DIV_Q_W-1]};
                lq    = {lq[DIV_Q_W-2:0], 1'b0};
                if (trial >= {1'b0, den})
                begin
                    rem   = DEN_W'(trial - {1'b0, den});
                    lq[0] = 1'b1;
                end
                else
                begin
                    rem = trial[DEN_W-1:0];
                end
            end
            rem_next[s] = rem;
            lq_next[s]  = lq;
        end

        // Hold on stall
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[s];
                lq_reg[s]  <= lq_next[s];
            end
        end
    end

    assign quo = lq_reg[DIV_STAGES-1];

endmodule

/* design/hgb_encode.sv */
// Gamma encoder: binary search of the threshold table, a few code bits per stage.
module hgb_encode (
    input  logic                clk,
    input  logic                en,
    input  hgb_pkg::lin_t       lin,
    output logic [7:0]          code
);
    import hgb_pkg::*;

    localparam int unsigned STEP = ENC_BITS / ENC_STAGES;

    lin_t       v_reg    [ENC_STAGES];
    logic [7:0] n_reg    [ENC_STAGES];
    lin_t       v_in     [ENC_STAGES];
    logic [7:0] n_in     [ENC_STAGES];
    logic [7:0] n_next   [ENC_STAGES];

    assign v_in[0] = lin;
    assign n_in[0] = 8'd0;
    for (genvar s = 1; s < ENC_STAGES; s++)
    begin : g_link
        assign v_in[s] = v_reg[s-1];
        assign n_in[s] = n_reg[s-1];
    end

    for (genvar s = 0; s < ENC_STAGES; s++)
    begin : g_stage
        // Try each code bit from the top, keep it where the threshold is met
        always_comb
        begin
            logic [7:0] n;
            logic [7:0] cand;
            n = n_in[s];
            for (int k = 0; k < STEP; k++)
            begin
                cand = n | (8'd1 << (ENC_BITS - 1 - s * STEP - k));
                if (ENC_TAB[cand] <= v_in[s])
                    n = cand;
            end
            n_next[s] = n;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s] <= v_in[s];
                n_reg[s] <= n_next[s];
            end
        end
    end

    assign code = n_reg[ENC_STAGES-1];

endmodule

/* design/hdr_gamma_blend_pixel.sv */
// Top level of the HDR gamma blend pixel block: decode, blend, divide, encode pipeline.
//
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_ready   | in_data   (pix_in_t)
//  out     | source    | out_valid / out_ready | out_data  (pix_out_t)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat enters per cycle while in_ready is high; each result passes
// through 11 register stages: decode, multiply, numerator, four divider
// stages, combine, two encoder stages and output.
// Reset clears the valid bits and the configuration registers only.
// A stall at the output holds every stage; in_ready falls only when the
// output register holds a beat that is not taken.
module hdr_gamma_blend_pixel #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hgb_pkg::pix_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hgb_pkg::pix_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import hgb_pkg::*;

    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned NUM_W = WW + DIV_Q_W;
    localparam int unsigned LAT   = 3 + DIV_STAGES + 1 + ENC_STAGES + 1;

    // Configuration registers
    logic [1:0]       blend_mode_reg;
    logic [HDR_W-1:0] hdr_reg [NUM_CH];
    logic [IW_W-1:0]  image_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg  <= MODE_RESET;
            hdr_reg[0]      <= RED_RESET;
            hdr_reg[1]      <= GREEN_RESET;
            hdr_reg[2]      <= BLUE_RESET;
            image_width_reg <= IW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BLEND_MODE:  blend_mode_reg  <= cfg_data[1:0];
                CFG_HDR_RED:     hdr_reg[0]      <= cfg_data;
                CFG_HDR_GREEN:   hdr_reg[1]      <= cfg_data;
                CFG_HDR_BLUE:    hdr_reg[2]      <= cfg_data;
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IW_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective width, mode decode: kept static by the user while beats are in flight
    logic [IW_W-1:0] iw_nz;
    logic [WW-1:0]   w_eff;
    logic            is_pma;
    logic            clamp_h;

    assign iw_nz   = (image_width_reg == '0) ? IW_W'(1) : image_width_reg;
    assign w_eff   = (32'(iw_nz) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(iw_nz);
    assign is_pma  = (blend_mode_reg == MODE_PREMUL);
    assign clamp_h = (blend_mode_reg == MODE_LERP_CLAMP);

    // Global advance: move when the output register is free or taken
    logic adv;
    logic vld_reg [LAT];

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Alpha travels alongside
    logic [7:0] alpha_reg [LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha_reg[0] <= in_data.in_alpha;
            for (int i = 1; i < LAT - 1; i++)
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    // Stage 1: decode to linear, clamp the column
    lin_t          s1_lin_reg [NUM_CH];
    logic [WW-1:0] s1_x_reg;
    logic [WW-1:0] x_eff;

    assign x_eff = (32'(in_data.column) > 32'(w_eff)) ? w_eff : WW'(in_data.column);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lin_reg[0] <= DEC_TAB[in_data.in_red];
            s1_lin_reg[1] <= DEC_TAB[in_data.in_green];
            s1_lin_reg[2] <= DEC_TAB[in_data.in_blue];
            s1_x_reg      <= x_eff;
        end
    end

    // Stage 2: weight source and target
    logic [LIN_W+WW-1:0] s2_pa_reg [NUM_CH];
    logic [HDR_W+WW-1:0] s2_ph_reg [NUM_CH];
    logic [HDR_W-1:0]    hsel [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
            hsel[c] = (clamp_h && hdr_reg[c] > HDR_W'(Q_ONE)) ? HDR_W'(Q_ONE) : hdr_reg[c];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                s2_pa_reg[c] <= (LIN_W+WW)'(s1_lin_reg[c]) * (LIN_W+WW)'(w_eff - s1_x_reg);
                s2_ph_reg[c] <= (HDR_W+WW)'(hsel[c]) * (HDR_W+WW)'(s1_x_reg);
            end
        end
    end

    // Stage 3: form the numerators
    logic [NUM_W-1:0] s3_num_a_reg [NUM_CH];
    logic [NUM_W-1:0] s3_num_b_reg [NUM_CH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                s3_num_a_reg[c] <= is_pma ? NUM_W'(s2_pa_reg[c])
                                          : NUM_W'(s2_pa_reg[c]) + NUM_W'(s2_ph_reg[c]);
                s3_num_b_reg[c] <= NUM_W'(s2_ph_reg[c]);
            end
        end
    end

    // Divide by the width
    logic [DIV_Q_W-1:0] quo_a [NUM_CH];
    logic [DIV_Q_W-1:0] quo_b [NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_div
        hgb_div #(.DEN_W(WW)) u_div_a (
            .clk (clk),
            .en  (adv),
            .num (s3_num_a_reg[c]),
            .den (w_eff),
            .quo (quo_a[c])
        );
        hgb_div #(.DEN_W(WW)) u_div_b (
            .clk (clk),
            .en  (adv),
            .num (s3_num_b_reg[c]),
            .den (w_eff),
            .quo (quo_b[c])
        );
    end

    // Combine stage: in premultiplied mode add the premultiplied part; flag and clamp
    logic [DIV_Q_W:0] v_sum [NUM_CH];
    logic [NUM_CH-1:0] v_over;
    lin_t             comb_lin_reg [NUM_CH];
    logic             over_reg [ENC_STAGES+1];

    always_comb
    begin
        logic [DIV_Q_W-1:0] qb_cl;
        for (int c = 0; c < NUM_CH; c++)
        begin
            qb_cl    = (quo_b[c] > DIV_Q_W'(Q_ONE)) ? DIV_Q_W'(Q_ONE) : quo_b[c];
            v_sum[c] = is_pma ? (DIV_Q_W+1)'(quo_a[c]) + (DIV_Q_W+1)'(qb_cl)
                              : (DIV_Q_W+1)'(quo_a[c]);
            v_over[c] = v_sum[c] > (DIV_Q_W+1)'(Q_ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
                comb_lin_reg[c] <= v_over[c] ? Q_ONE : v_sum[c][LIN_W-1:0];
            over_reg[0] <= |v_over;
            for (int i = 1; i <= ENC_STAGES; i++)
                over_reg[i] <= over_reg[i-1];
        end
    end

    // Encode back to bytes
    logic [7:0] code [NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_enc
        hgb_encode u_enc (
            .clk  (clk),
            .en   (adv),
            .lin  (comb_lin_reg[c]),
            .code (code[c])
        );
    end

    // Output register: mark clipped pixels red
    pix_out_t out_data_reg;
    pix_out_t out_data_next;

    always_comb
    begin
        out_data_next.out_red    = code[0];
        out_data_next.out_green  = code[1];
        out_data_next.out_blue   = code[2];
        out_data_next.out_alpha  = alpha_reg[LAT-2];
        out_data_next.over_range = over_reg[ENC_STAGES];
        out_data_next.clip_red   = over_reg[ENC_STAGES] ? 8'd255 : code[0];
        out_data_next.clip_green = over_reg[ENC_STAGES] ? 8'd0 : code[1];
        out_data_next.clip_blue  = over_reg[ENC_STAGES] ? 8'd0 : code[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

/* tb/sv/tb_hdr_gamma_blend_pixel.sv */
// Testbench for the HDR gamma blend pixel block: queued stimulus, in-bench predictor, beat checker.
module tb_hdr_gamma_blend_pixel;
    import hgb_pkg::*;

    localparam int unsigned WIDTH_CAP = 4096;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam logic [63:0] LIN_ONE = 64'd8192;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pix_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pix_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Pixels waiting to be driven and results awaited
    pix_in_t pixel_queue[$];
    pix_out_t expected_pixels[$];

    // Shadow copy of the block's registers
    logic [1:0] mode_shadow = MODE_RESET;
    logic [15:0] red_shadow = RED_RESET;
    logic [15:0] green_shadow = GREEN_RESET;
    logic [15:0] blue_shadow = BLUE_RESET;
    logic [12:0] width_shadow = IW_RESET;

    logic [63:0] gamma_q31 [256];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;

    hdr_gamma_blend_pixel DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // (b/255)^2.2 in Q1.31: square times a bisected fifth root
    function automatic logic [63:0] srgb_to_q31(int unsigned b);
        logic [63:0] r;
        logic [63:0] sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        r = (64'(b) << 31) / 64'd255;
        sq = ((64'(b) * 64'(b)) << 31) / 64'd65025;
        lo = 64'd0;
        hi = 64'd1 << 31;
        while (lo < hi)
        begin
            mid = (lo + hi + 64'd1) >> 1;
            p = mid;
            for (int i = 0; i < 4; i++)
            begin
                p = (p * mid) >> 31;
            end
            if (p <= r)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return (sq * lo) >> 31;
    endfunction

    function automatic logic [63:0] mix_channel(logic [63:0] a, logic [63:0] h,
                                                logic [63:0] x, logic [63:0] w);
        logic [63:0] pma;
        if (mode_shadow == MODE_PREMUL)
        begin
            pma = (h * x) / w;
            if (pma > LIN_ONE)
                pma = LIN_ONE;
            return (a * (w - x)) / w + pma;
        end
        if (mode_shadow == MODE_LERP_CLAMP && h > LIN_ONE)
            h = LIN_ONE;
        return (a * (w - x) + h * x) / w;
    endfunction

    function automatic logic [7:0] lin_to_srgb(logic [63:0] v);
        logic [7:0] n;
        n = '0;
        if (v > LIN_ONE)
            v = LIN_ONE;
        for (int b = 1; b < 256; b++)
        begin
            if (gamma_q31[b] <= (v << 18))
                n++;
        end
        return n;
    endfunction

    function automatic pix_out_t blend_pixel(pix_in_t p);
        pix_out_t o;
        logic [63:0] w;
        logic [63:0] x;
        logic [63:0] vr;
        logic [63:0] vg;
        logic [63:0] vb;
        w = 64'(width_shadow);
        x = 64'(p.column);
        if (w == 64'd0)
            w = 64'd1;
        if (w > 64'(WIDTH_CAP))
            w = 64'(WIDTH_CAP);
        if (x > w)
            x = w;
        vr = mix_channel((gamma_q31[p.in_red] + (64'd1 << 17)) >> 18,
                         64'(red_shadow), x, w);
        vg = mix_channel((gamma_q31[p.in_green] + (64'd1 << 17)) >> 18,
                         64'(green_shadow), x, w);
        vb = mix_channel((gamma_q31[p.in_blue] + (64'd1 << 17)) >> 18,
                         64'(blue_shadow), x, w);
        o.over_range = (vr > LIN_ONE) || (vg > LIN_ONE) || (vb > LIN_ONE);
        o.out_red = lin_to_srgb(vr);
        o.out_green = lin_to_srgb(vg);
        o.out_blue = lin_to_srgb(vb);
        o.out_alpha = p.in_alpha;
        o.clip_red = o.over_range ? 8'd255 : o.out_red;
        o.clip_green = o.over_range ? 8'd0 : o.out_green;
        o.clip_blue = o.over_range ? 8'd0 : o.out_blue;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // Drive pixel beats, holding each until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(blend_pixel(in_data));
                void'(pixel_queue.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pixel_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check result beats against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    pix_out_t e;
                    e = expected_pixels.pop_front();
                    if (out_data.out_red !== e.out_red)
                        report_mismatch("out_red", out_data.out_red, e.out_red);
                    if (out_data.out_green !== e.out_green)
                        report_mismatch("out_green", out_data.out_green, e.out_green);
                    if (out_data.out_blue !== e.out_blue)
                        report_mismatch("out_blue", out_data.out_blue, e.out_blue);
                    if (out_data.out_alpha !== e.out_alpha)
                        report_mismatch("out_alpha", out_data.out_alpha, e.out_alpha);
                    if (out_data.clip_red !== e.clip_red)
                        report_mismatch("clip_red", out_data.clip_red, e.clip_red);
                    if (out_data.clip_green !== e.clip_green)
                        report_mismatch("clip_green", out_data.clip_green, e.clip_green);
                    if (out_data.clip_blue !== e.clip_blue)
                        report_mismatch("clip_blue", out_data.clip_blue, e.clip_blue);
                    if (out_data.over_range !== e.over_range)
                        report_mismatch("over_range", out_data.over_range, e.over_range);
                end
            end
            // Long hold-off counts down first, then random stalls
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BLEND_MODE: mode_shadow = value[1:0];
            CFG_HDR_RED: red_shadow = value;
            CFG_HDR_GREEN: green_shadow = value;
            CFG_HDR_BLUE: blue_shadow = value;
            CFG_IMAGE_WIDTH: width_shadow = value[12:0];
            default: ;
        endcase
        // Let cfg_valid fall before the next write so it starts in a fresh step
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pix_in_t random_pixel(input int unsigned w);
        pix_in_t p;
        p.in_red = 8'($urandom_range(255));
        p.in_green = 8'($urandom_range(255));
        p.in_blue = 8'($urandom_range(255));
        p.in_alpha = 8'($urandom_range(255));
        // Mostly columns inside the row, some past its end
        if ($urandom_range(9) == 0)
            p.column = 12'($urandom_range(4095));
        else
            p.column = 12'($urandom_range((w == 0 ? 1 : (w > 4096 ? 4096 : w)) - 1));
        return p;
    endfunction

    initial
    begin
        pix_in_t p;
        logic [12:0] widths [8];
        for (int b = 0; b < 256; b++)
        begin
            gamma_q31[b] = srgb_to_q31(b);
        end
        widths = '{13'd1, 13'd2, 13'd0, 13'd4096, 13'd8191, 13'd17, 13'd640, 13'd1024};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, column ends and past-width at reset settings
        for (int i = 0; i < 4; i++)
        begin
            p.in_red = (i[0]) ? 8'd255 : 8'd0;
            p.in_green = (i[1]) ? 8'd255 : 8'd0;
            p.in_blue = (i == 3) ? 8'd255 : 8'd1;
            p.in_alpha = (i[0]) ? 8'd0 : 8'd255;
            p.column = (i == 0) ? 12'd0 : ((i == 1) ? 12'd1023 : 12'd4095);
            pixel_queue.push_back(p);
        end
        wait_idle();
        // Every mode incl. the unused one, with zero and oversized widths
        for (int m = 0; m < 4; m++)
        begin
            write_register(CFG_BLEND_MODE, 16'(m));
            write_register(CFG_IMAGE_WIDTH, 16'(widths[m + 1]));
            write_register(CFG_HDR_RED, (m == 0) ? 16'hFFFF : 16'd8192);
            write_register(CFG_HDR_GREEN, (m == 1) ? 16'd0 : 16'd9000);
            write_register(CFG_HDR_BLUE, 16'(m * 5000));
            for (int i = 0; i < 5; i++)
            begin
                pixel_queue.push_back(random_pixel(32'(widths[m + 1])));
            end
            p = random_pixel(1);
            p.column = 12'd4095;
            pixel_queue.push_back(p);
            wait_idle();
        end

        // Random phases under the three idle patterns, with changing settings
        for (int ph = 0; ph < 12; ph++)
        begin
            int unsigned w;
            send_idle_pct = (ph < 4) ? 24 : ((ph < 8) ? 60 : 0);
            recv_idle_pct = (ph < 4) ? 60 : ((ph < 8) ? 24 : 0);
            w = 32'(widths[$urandom_range(7)]);
            write_register(CFG_BLEND_MODE, 16'($urandom_range(3)));
            write_register(CFG_HDR_RED, 16'($urandom_range(65535)));
            write_register(CFG_HDR_GREEN, 16'($urandom_range(16384)));
            write_register(CFG_HDR_BLUE, 16'($urandom_range(9000)));
            write_register(CFG_IMAGE_WIDTH, 16'(w));
            for (int i = 0; i < 140; i++)
            begin
                pixel_queue.push_back(random_pixel(w));
            end
            // Stall the output long enough to back the pipeline up
            if (ph == 9)
                hold_cycles = 200;
            wait_idle();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
